### src/wfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform feature extractor package
// Shared widths, register codes, reset values and defaults.
// ----------------------------------------------------------------------------
package wfe_pkg;

   localparam int DEFAULT_WAVEFORM_LENGTH = 128;
   localparam int DEFAULT_LEAD_SCAN_DEPTH = 10;
   localparam int DEFAULT_SAMPLE_BITS     = 13;

   localparam int ACT_BITS       = 12;
   localparam int THRESH_BITS    = 13;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;

   localparam int PEAK_BITS    = 13;
   localparam int COUNT_BITS   = 9;
   localparam int ARRIVAL_BITS = 8;
   localparam int WIDTH_BITS   = 9;
   localparam int AMP_BITS     = 14;

   localparam int COUNT_MAX       = 511;
   localparam int FAR_DISTANCE    = 999;
   localparam int TAIL_WAIT_START = 2;

   localparam logic [ACT_BITS-1:0]           ACTIVATION_RESET = 12'd30;
   localparam logic [ACT_BITS-1:0]           OUTLIER_RESET    = 12'd20;
   localparam logic signed [THRESH_BITS-1:0] HIGH_RESET       = 13'sd110;
   localparam logic signed [THRESH_BITS-1:0] LOW_RESET        = 13'sd90;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ACTIVATION_THRESHOLD  = 2'd0,
      CSR_OUTLIER_DIFFERENCE    = 2'd1,
      CSR_HIGH_TIMING_THRESHOLD = 2'd2,
      CSR_LOW_TIMING_THRESHOLD  = 2'd3
   } csr_index_type;

endpackage

### src/waveform_feature_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform feature extractor
// Per-sample peak, timing-crossing and afterpulse tracking with a result on
// the last sample of each waveform.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one signed sample per transaction; req_waveform_last marks
//   the final sample of a waveform. rsp_* carries one feature transaction per
//   waveform, produced only for the final sample. csr_* writes the four
//   threshold registers; write them only while no waveform is in flight.
// Flow: an accepted sample waits in the input register, then is processed into
//   the state registers; a final sample also loads the result register.
// Throughput: one sample per cycle outside the stall below, set by the single
//   input register and single-pass feature logic before the state registers.
// Stall: a result held under rsp_stall blocks only the next final sample in
//   the input register; other samples keep flowing. req_stall rises only then.
// Reset: thresholds return to their defaults, all per-waveform state clears
//   and both channels go empty. Per-waveform state also clears after each
//   result.
// ----------------------------------------------------------------------------
module waveform_feature_extractor #(
   parameter int WAVEFORM_LENGTH = wfe_pkg::DEFAULT_WAVEFORM_LENGTH,
   parameter int LEAD_SCAN_DEPTH = wfe_pkg::DEFAULT_LEAD_SCAN_DEPTH,
   parameter int SAMPLE_BITS     = wfe_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_value,
   input  logic                                 req_waveform_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_activated,
   output logic signed [wfe_pkg::PEAK_BITS-1:0] rsp_peak_value,
   output logic [wfe_pkg::COUNT_BITS-1:0]       rsp_near_peak_count,
   output logic [wfe_pkg::ARRIVAL_BITS-1:0]     rsp_arrival_half_samples,
   output logic signed [wfe_pkg::WIDTH_BITS-1:0] rsp_width_half_samples,
   output logic                                 rsp_afterpulse_seen,
   output logic signed [wfe_pkg::AMP_BITS-1:0]  rsp_afterpulse_amplitude,
   input  logic                                 csr_write_enable,
   input  logic [wfe_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wfe_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int SB           = SAMPLE_BITS;
   localparam int TB           = wfe_pkg::THRESH_BITS;
   localparam int CW           = ((SB > TB) ? SB : TB) + 3;
   localparam int HIST_DEPTH   = 2 * LEAD_SCAN_DEPTH;
   localparam int BACK_BITS    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int STEP_BITS    = $clog2(LEAD_SCAN_DEPTH + 1);
   localparam int IDX_BITS     = $clog2(WAVEFORM_LENGTH);
   localparam int CNT_BITS     = $clog2(WAVEFORM_LENGTH + 1);
   localparam int CMPW         = IDX_BITS + STEP_BITS;
   localparam int PEAK_BITS    = wfe_pkg::PEAK_BITS;
   localparam int COUNT_BITS   = wfe_pkg::COUNT_BITS;
   localparam int ARRIVAL_BITS = wfe_pkg::ARRIVAL_BITS;
   localparam int WIDTH_BITS   = wfe_pkg::WIDTH_BITS;
   localparam int AMP_BITS     = wfe_pkg::AMP_BITS;

   localparam logic [CNT_BITS-1:0]    LENGTH_LIMIT = CNT_BITS'(WAVEFORM_LENGTH);
   localparam logic [CNT_BITS-1:0]    FIRST_PROC   = CNT_BITS'(2);
   localparam logic [STEP_BITS-1:0]   STEP_IDLE    = STEP_BITS'(LEAD_SCAN_DEPTH);
   localparam logic [CW-1:0]          FAR_DIST     = CW'(wfe_pkg::FAR_DISTANCE);
   localparam logic signed [CW-1:0]   SEVEN        = CW'(7);
   localparam logic [1:0]             TAIL_START   = 2'(wfe_pkg::TAIL_WAIT_START);
   localparam logic [COUNT_BITS:0]    COUNT_SAT    = (COUNT_BITS + 1)'(wfe_pkg::COUNT_MAX);

   // configuration
   logic [wfe_pkg::ACT_BITS-1:0] act_thr_ff;
   logic [wfe_pkg::ACT_BITS-1:0] outlier_ff;
   logic signed [TB-1:0]         high_thr_ff;
   logic signed [TB-1:0]         low_thr_ff;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [SB-1:0] s1_sample_ff;
   logic                 s1_last_ff;
   logic                 advance;

   // waveform state
   logic signed [SB-1:0]  hist_ff [HIST_DEPTH];
   logic signed [SB-1:0]  hist_in [HIST_DEPTH];
   logic [CNT_BITS-1:0]   sample_index_ff, sample_index_in;
   logic signed [SB-1:0]  peak_ff, peak_in;
   logic [IDX_BITS-1:0]   peak_index_ff, peak_index_in;
   logic [STEP_BITS-1:0]  lead_step_ff, lead_step_in;
   logic [1:0]            tail_wait_ff, tail_wait_in;
   logic                  active_ff, active_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [CW-1:0]         lead_best_ff [2];
   logic [CW-1:0]         lead_best_in [2];
   logic [CW-1:0]         tail_best_ff [2];
   logic [CW-1:0]         tail_best_in [2];
   logic [IDX_BITS-1:0]   cross_ff [4];
   logic [IDX_BITS-1:0]   cross_in [4];
   logic                  ap_flag_ff, ap_flag_in;
   logic signed [SB-1:0]  ap_max_ff, ap_max_in;
   logic signed [SB-1:0]  ap_start_ff, ap_start_in;
   logic signed [SB:0]    ap_amp_ff, ap_amp_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_activated_ff, rsp_activated_in;
   logic signed [PEAK_BITS-1:0]   rsp_peak_ff, rsp_peak_in;
   logic [COUNT_BITS-1:0]         rsp_count_ff, rsp_count_in;
   logic [ARRIVAL_BITS-1:0]       rsp_arrival_ff, rsp_arrival_in;
   logic signed [WIDTH_BITS-1:0]  rsp_width_ff, rsp_width_in;
   logic                          rsp_ap_seen_ff, rsp_ap_seen_in;
   logic signed [AMP_BITS-1:0]    rsp_amp_ff, rsp_amp_in;

   // feature logic
   logic signed [SB-1:0]   hist_shift [HIST_DEPTH];
   logic signed [CW-1:0]   x0_w, x1_w, x2_w, peak_w, act_w, od_w, high_w, low_w;
   logic signed [CW-1:0]   diff_left, diff_right, avg_sum, avg_adj, avg_val;
   logic signed [CW-1:0]   p7, p7_adj, thr7;
   logic signed [CW-1:0]   scan_w, dh_raw, dl_raw;
   logic [CW-1:0]          dh_abs, dl_abs;
   logic [BACK_BITS-1:0]   back;
   logic                   lead_bump, x0_bump;
   logic [COUNT_BITS:0]    count_sum;
   logic [IDX_BITS:0]      lead_sum, tail_sum;
   logic signed [IDX_BITS+1:0] width_diff;

   assign advance     = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign s1_valid_in = (req_valid && !req_stall) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_comb begin
      hist_shift[0] = s1_sample_ff;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         hist_shift[i] = hist_ff[i-1];
      end
   end

   assign x0_w   = CW'(s1_sample_ff);
   assign x1_w   = CW'(hist_ff[0]);
   assign x2_w   = CW'(hist_ff[1]);
   assign act_w  = CW'({1'b0, act_thr_ff});
   assign od_w   = CW'({1'b0, outlier_ff});
   assign high_w = CW'(high_thr_ff);
   assign low_w  = CW'(low_thr_ff);

   always_comb begin
      hist_in         = hist_ff;
      sample_index_in = sample_index_ff;
      peak_in         = peak_ff;
      peak_index_in   = peak_index_ff;
      lead_step_in    = lead_step_ff;
      tail_wait_in    = tail_wait_ff;
      active_in       = active_ff;
      count_in        = count_ff;
      lead_best_in    = lead_best_ff;
      tail_best_in    = tail_best_ff;
      cross_in        = cross_ff;
      ap_flag_in      = ap_flag_ff;
      ap_max_in       = ap_max_ff;
      ap_start_in     = ap_start_ff;
      ap_amp_in       = ap_amp_ff;
      diff_left       = x1_w - x2_w;
      diff_right      = x1_w - x0_w;
      avg_sum         = x2_w + x0_w;
      avg_adj         = avg_sum + (avg_sum[CW-1] ? CW'(1) : CW'(0));
      avg_val         = avg_adj >>> 1;
      peak_w          = '0;
      p7              = '0;
      p7_adj          = '0;
      thr7            = '0;
      back            = '0;
      scan_w          = '0;
      dh_raw          = '0;
      dl_raw          = '0;
      dh_abs          = '0;
      dl_abs          = '0;
      lead_bump       = 1'b0;
      x0_bump         = 1'b0;
      count_sum       = '0;

      if (advance && (sample_index_ff < LENGTH_LIMIT)) begin
         hist_in         = hist_shift;
         sample_index_in = sample_index_ff + 1'b1;
         if (sample_index_ff >= FIRST_PROC) begin
            // new peak
            if (x1_w > CW'(peak_ff) && x1_w > act_w) begin
               active_in     = 1'b1;
               peak_index_in = IDX_BITS'(sample_index_ff - 1'b1);
               if (diff_left < od_w && diff_right < od_w) begin
                  peak_in = hist_ff[0];
               end else begin
                  peak_in = SB'(avg_val);
               end
               lead_step_in = '0;
               lead_best_in = '{FAR_DIST, FAR_DIST};
               tail_best_in = '{FAR_DIST, FAR_DIST};
               cross_in     = '{default: '0};
               count_in     = COUNT_BITS'(1);
               tail_wait_in = TAIL_START;
               ap_flag_in   = 1'b0;
               ap_amp_in    = '0;
            end
            peak_w = CW'(peak_in);
            p7     = (peak_w <<< 3) - peak_w;
            p7_adj = p7 + (p7[CW-1] ? SEVEN : CW'(0));
            thr7   = p7_adj >>> 3;

            // lead scan, walk back from the peak
            if (lead_step_in < STEP_IDLE &&
                CMPW'(peak_index_in) >= CMPW'(lead_step_in)) begin
               back      = BACK_BITS'({lead_step_in, 1'b1});
               scan_w    = CW'(hist_shift[back]);
               lead_bump = active_in && (scan_w > thr7);
               dh_raw    = scan_w - high_w;
               dl_raw    = scan_w - low_w;
               dh_abs    = dh_raw[CW-1] ? CW'(-dh_raw) : CW'(dh_raw);
               dl_abs    = dl_raw[CW-1] ? CW'(-dl_raw) : CW'(dl_raw);
               if (dh_abs < lead_best_in[0]) begin
                  lead_best_in[0] = dh_abs;
                  cross_in[0]     = IDX_BITS'(CMPW'(peak_index_in) - CMPW'(lead_step_in));
               end
               if (dl_abs < lead_best_in[1]) begin
                  lead_best_in[1] = dl_abs;
                  cross_in[1]     = IDX_BITS'(CMPW'(peak_index_in) - CMPW'(lead_step_in));
               end
            end

            // tail scan and afterpulse
            if (active_in && tail_wait_in == 2'd0) begin
               if (x0_w > x1_w && x1_w > x2_w && !ap_flag_in) begin
                  ap_flag_in  = 1'b1;
                  ap_max_in   = s1_sample_ff;
                  ap_start_in = hist_ff[1];
               end
               if (ap_flag_in && x0_w > CW'(ap_max_in)) begin
                  ap_max_in = s1_sample_ff;
                  ap_amp_in = (SB + 1)'(s1_sample_ff) - (SB + 1)'(ap_start_in);
               end
               dh_raw = x0_w - high_w;
               dl_raw = x0_w - low_w;
               dh_abs = dh_raw[CW-1] ? CW'(-dh_raw) : CW'(dh_raw);
               dl_abs = dl_raw[CW-1] ? CW'(-dl_raw) : CW'(dl_raw);
               if (dh_abs < tail_best_in[0]) begin
                  tail_best_in[0] = dh_abs;
                  cross_in[2]     = IDX_BITS'(sample_index_ff);
               end
               if (dl_abs < tail_best_in[1]) begin
                  tail_best_in[1] = dl_abs;
                  cross_in[3]     = IDX_BITS'(sample_index_ff);
               end
            end

            x0_bump   = active_in && (x0_w > thr7);
            count_sum = (COUNT_BITS + 1)'(count_in) + (COUNT_BITS + 1)'(lead_bump)
                        + (COUNT_BITS + 1)'(x0_bump);
            count_in  = (count_sum > COUNT_SAT) ? COUNT_SAT[COUNT_BITS-1:0]
                                                : count_sum[COUNT_BITS-1:0];
            if (tail_wait_in != 2'd0) begin
               tail_wait_in = tail_wait_in - 1'b1;
            end
            if (lead_step_in < STEP_IDLE) begin
               lead_step_in = lead_step_in + 1'b1;
            end
         end
      end

      // result fields from the updated state
      lead_sum         = (IDX_BITS + 1)'(cross_in[0]) + (IDX_BITS + 1)'(cross_in[1]);
      tail_sum         = (IDX_BITS + 1)'(cross_in[2]) + (IDX_BITS + 1)'(cross_in[3]);
      width_diff       = (IDX_BITS + 2)'(tail_sum) - (IDX_BITS + 2)'(lead_sum);
      rsp_activated_in = active_in;
      rsp_peak_in      = PEAK_BITS'(peak_in);
      rsp_count_in     = count_in;
      rsp_arrival_in   = ARRIVAL_BITS'(lead_sum);
      rsp_width_in     = WIDTH_BITS'(width_diff);
      rsp_ap_seen_in   = ap_flag_in;
      rsp_amp_in       = AMP_BITS'(ap_amp_in);

      // clear per-waveform state on reset and after a result
      if (reset || (advance && s1_last_ff)) begin
         hist_in         = '{default: '0};
         sample_index_in = '0;
         peak_in         = '0;
         peak_index_in   = '0;
         lead_step_in    = STEP_IDLE;
         tail_wait_in    = TAIL_START;
         active_in       = 1'b0;
         count_in        = '0;
         lead_best_in    = '{FAR_DIST, FAR_DIST};
         tail_best_in    = '{FAR_DIST, FAR_DIST};
         cross_in        = '{default: '0};
         ap_flag_in      = 1'b0;
         ap_max_in       = '0;
         ap_start_in     = '0;
         ap_amp_in       = '0;
      end
   end

   always_comb begin
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_thr_ff   <= wfe_pkg::ACTIVATION_RESET;
         outlier_ff   <= wfe_pkg::OUTLIER_RESET;
         high_thr_ff  <= wfe_pkg::HIGH_RESET;
         low_thr_ff   <= wfe_pkg::LOW_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               wfe_pkg::CSR_ACTIVATION_THRESHOLD: begin
                  act_thr_ff <= csr_write_data[wfe_pkg::ACT_BITS-1:0];
               end
               wfe_pkg::CSR_OUTLIER_DIFFERENCE: begin
                  outlier_ff <= csr_write_data[wfe_pkg::ACT_BITS-1:0];
               end
               wfe_pkg::CSR_HIGH_TIMING_THRESHOLD: begin
                  high_thr_ff <= csr_write_data[TB-1:0];
               end
               wfe_pkg::CSR_LOW_TIMING_THRESHOLD: begin
                  low_thr_ff <= csr_write_data[TB-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // waveform state; the clear path above also covers reset
   always_ff @(posedge clock) begin
      hist_ff         <= hist_in;
      sample_index_ff <= sample_index_in;
      peak_ff         <= peak_in;
      peak_index_ff   <= peak_index_in;
      lead_step_ff    <= lead_step_in;
      tail_wait_ff    <= tail_wait_in;
      active_ff       <= active_in;
      count_ff        <= count_in;
      lead_best_ff    <= lead_best_in;
      tail_best_ff    <= tail_best_in;
      cross_ff        <= cross_in;
      ap_flag_ff      <= ap_flag_in;
      ap_max_ff       <= ap_max_in;
      ap_start_ff     <= ap_start_in;
      ap_amp_ff       <= ap_amp_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_sample_ff <= req_sample_value;
         s1_last_ff   <= req_waveform_last;
      end
      if (advance && s1_last_ff) begin
         rsp_activated_ff <= rsp_activated_in;
         rsp_peak_ff      <= rsp_peak_in;
         rsp_count_ff     <= rsp_count_in;
         rsp_arrival_ff   <= rsp_arrival_in;
         rsp_width_ff     <= rsp_width_in;
         rsp_ap_seen_ff   <= rsp_ap_seen_in;
         rsp_amp_ff       <= rsp_amp_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_activated            = rsp_activated_ff;
   assign rsp_peak_value           = rsp_peak_ff;
   assign rsp_near_peak_count      = rsp_count_ff;
   assign rsp_arrival_half_samples = rsp_arrival_ff;
   assign rsp_width_half_samples   = rsp_width_ff;
   assign rsp_afterpulse_seen      = rsp_ap_seen_ff;
   assign rsp_afterpulse_amplitude = rsp_amp_ff;

endmodule

### src/wfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform feature extractor checker
// Port-level properties of the feature extractor, bound to the top level.
// ----------------------------------------------------------------------------
module wfe_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_activated,
   input logic signed [wfe_pkg::PEAK_BITS-1:0]  rsp_peak_value,
   input logic [wfe_pkg::COUNT_BITS-1:0]        rsp_near_peak_count,
   input logic [wfe_pkg::ARRIVAL_BITS-1:0]      rsp_arrival_half_samples,
   input logic signed [wfe_pkg::WIDTH_BITS-1:0] rsp_width_half_samples,
   input logic                                  rsp_afterpulse_seen,
   input logic signed [wfe_pkg::AMP_BITS-1:0]   rsp_afterpulse_amplitude
);

   // hold a stalled transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_peak_value)
         && $stable(rsp_near_peak_count) && $stable(rsp_afterpulse_amplitude))
      else $error("stalled result changed");

   // a waveform that never activated reports all zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_activated |-> rsp_peak_value == '0
         && rsp_near_peak_count == '0 && rsp_arrival_half_samples == '0
         && rsp_width_half_samples == '0 && !rsp_afterpulse_seen)
      else $error("inactive waveform reported features");

   // an activated waveform has counted its peak, amplitude needs an afterpulse
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_activated || rsp_near_peak_count != '0)
         && (rsp_afterpulse_seen || rsp_afterpulse_amplitude == '0))
      else $error("feature fields inconsistent");

   // drop back-pressure unless a result is held
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled without a held result");

endmodule

bind waveform_feature_extractor wfe_checker u_wfe_checker (.*);

### tb/wfe_feature_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform feature checker
// Watches the sample, feature and register ports of the extractor. Every
// accepted sample goes through a cycle-free copy of the per-waveform feature
// logic. Each final sample queues the predicted features. Each accepted
// feature transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wfe_feature_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [wfe_pkg::DEFAULT_SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                  req_waveform_last,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_activated,
   input  logic signed [wfe_pkg::PEAK_BITS-1:0]  rsp_peak_value,
   input  logic [wfe_pkg::COUNT_BITS-1:0]        rsp_near_peak_count,
   input  logic [wfe_pkg::ARRIVAL_BITS-1:0]      rsp_arrival_half_samples,
   input  logic signed [wfe_pkg::WIDTH_BITS-1:0] rsp_width_half_samples,
   input  logic                                  rsp_afterpulse_seen,
   input  logic signed [wfe_pkg::AMP_BITS-1:0]   rsp_afterpulse_amplitude,
   input  logic                                  csr_write_enable,
   input  logic [wfe_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [wfe_pkg::CSR_DATA_BITS-1:0]     csr_write_data,
   output int                                    error_count,
   output int                                    pending_count,
   output int                                    result_count
);

   import wfe_pkg::*;

   localparam int WAVE_LEN      = DEFAULT_WAVEFORM_LENGTH;
   localparam int SCAN_DEPTH    = DEFAULT_LEAD_SCAN_DEPTH;
   localparam int HISTORY_DEPTH = 2 * SCAN_DEPTH;

   typedef struct packed {
      logic                          activated;
      logic signed [PEAK_BITS-1:0]   peak;
      logic [COUNT_BITS-1:0]         count;
      logic [ARRIVAL_BITS-1:0]       arrival;
      logic signed [WIDTH_BITS-1:0]  width;
      logic                          seen;
      logic signed [AMP_BITS-1:0]    amp;
   } feature_t;

   int act_level;
   int outlier_level;
   int high_level;
   int low_level;

   logic signed [DEFAULT_SAMPLE_BITS-1:0] history [HISTORY_DEPTH];
   int sample_pos;
   int peak;
   int peak_pos;
   int lead_pos;
   int tail_delay;
   int near_count;
   bit armed;
   bit ap_seen;
   int ap_top;
   int ap_base;
   int ap_gain;
   // lead high, lead low, tail high, tail low
   int best_dist [4];
   int crossing [4];

   feature_t expected_features [$];

   task automatic clear_waveform();
      for (int m = 0; m < HISTORY_DEPTH; m++) history[m] = '0;
      for (int k = 0; k < 4; k++) begin
         best_dist[k] = FAR_DISTANCE;
         crossing[k]  = 0;
      end
      sample_pos = 0;
      peak       = 0;
      peak_pos   = 0;
      lead_pos   = SCAN_DEPTH;
      tail_delay = TAIL_WAIT_START;
      armed      = 1'b0;
      near_count = 0;
      ap_seen    = 1'b0;
      ap_top     = 0;
      ap_base    = 0;
      ap_gain    = 0;
   endtask

   task automatic note_crossing(input int s, input int at, input int slot);
      int dh;
      int dl;
      dh = (s > high_level) ? s - high_level : high_level - s;
      dl = (s > low_level) ? s - low_level : low_level - s;
      if (dh < best_dist[slot]) begin
         best_dist[slot] = dh;
         crossing[slot]  = at;
      end
      if (dl < best_dist[slot+1]) begin
         best_dist[slot+1] = dl;
         crossing[slot+1]  = at;
      end
   endtask

   task automatic count_near(input int s);
      if (armed && s > (7 * peak) / 8 && near_count < COUNT_MAX) near_count++;
   endtask

   task automatic evaluate_sample(input int j);
      int x0;
      int x1;
      int x2;
      int back;
      x0 = history[0];
      x1 = history[1];
      x2 = history[2];
      if (x1 > peak && x1 > act_level) begin
         armed    = 1'b1;
         peak_pos = j - 1;
         if (x1 - x2 < outlier_level && x1 - x0 < outlier_level) peak = x1;
         else peak = (x2 + x0) / 2;
         lead_pos = 0;
         for (int k = 0; k < 4; k++) begin
            best_dist[k] = FAR_DISTANCE;
            crossing[k]  = 0;
         end
         near_count = 1;
         tail_delay = TAIL_WAIT_START;
         ap_seen    = 1'b0;
         ap_gain    = 0;
      end
      if (lead_pos < SCAN_DEPTH && peak_pos >= lead_pos) begin
         back = 2 * lead_pos + 1;
         if (back < HISTORY_DEPTH) begin
            count_near(history[back]);
            note_crossing(history[back], peak_pos - lead_pos, 0);
         end
      end
      if (armed && tail_delay == 0) begin
         if (x0 > x1 && x1 > x2 && !ap_seen) begin
            ap_seen = 1'b1;
            ap_top  = x0;
            ap_base = x2;
         end
         if (ap_seen && x0 > ap_top) begin
            ap_top  = x0;
            ap_gain = ap_top - ap_base;
         end
         note_crossing(x0, j, 2);
      end
      count_near(x0);
      if (tail_delay > 0) tail_delay--;
      if (lead_pos < SCAN_DEPTH) lead_pos++;
   endtask

   task automatic absorb_sample(input int value, input bit last, output bit emits,
                                output feature_t f);
      int lead_sum;
      int spread;
      if (sample_pos < WAVE_LEN) begin
         for (int m = HISTORY_DEPTH - 1; m > 0; m--) history[m] = history[m-1];
         history[0] = value[DEFAULT_SAMPLE_BITS-1:0];
         if (sample_pos >= 2) evaluate_sample(sample_pos);
         sample_pos++;
      end
      emits = last;
      f     = '0;
      if (last) begin
         lead_sum    = crossing[0] + crossing[1];
         spread      = crossing[2] + crossing[3] - lead_sum;
         f.activated = armed;
         f.peak      = peak[PEAK_BITS-1:0];
         f.count     = near_count[COUNT_BITS-1:0];
         f.arrival   = lead_sum[ARRIVAL_BITS-1:0];
         f.width     = spread[WIDTH_BITS-1:0];
         f.seen      = ap_seen;
         f.amp       = ap_gain[AMP_BITS-1:0];
         clear_waveform();
      end
   endtask

   always @(posedge clock) begin : monitor
      feature_t got;
      feature_t want;
      bit emits;
      if (reset) begin
         act_level     = ACTIVATION_RESET;
         outlier_level = OUTLIER_RESET;
         high_level    = HIGH_RESET;
         low_level     = LOW_RESET;
         clear_waveform();
         expected_features.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_activated, rsp_peak_value, rsp_near_peak_count,
                    rsp_arrival_half_samples, rsp_width_half_samples,
                    rsp_afterpulse_seen, rsp_afterpulse_amplitude};
            result_count++;
            if (expected_features.size() == 0) begin
               $error("feature transaction with no waveform pending");
               error_count++;
            end else begin
               want = expected_features.pop_front();
               if (got.activated !== want.activated) begin
                  $error("activated: expected %0d, actual %0d", want.activated, got.activated);
                  error_count++;
               end
               if (got.peak !== want.peak) begin
                  $error("peak_value: expected %0d, actual %0d", want.peak, got.peak);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $error("near_peak_count: expected %0d, actual %0d", want.count, got.count);
                  error_count++;
               end
               if (got.arrival !== want.arrival) begin
                  $error("arrival_half_samples: expected %0d, actual %0d",
                         want.arrival, got.arrival);
                  error_count++;
               end
               if (got.width !== want.width) begin
                  $error("width_half_samples: expected %0d, actual %0d",
                         want.width, got.width);
                  error_count++;
               end
               if (got.seen !== want.seen) begin
                  $error("afterpulse_seen: expected %0d, actual %0d", want.seen, got.seen);
                  error_count++;
               end
               if (got.amp !== want.amp) begin
                  $error("afterpulse_amplitude: expected %0d, actual %0d",
                         want.amp, got.amp);
                  error_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ACTIVATION_THRESHOLD:  act_level     = csr_write_data[ACT_BITS-1:0];
               CSR_OUTLIER_DIFFERENCE:    outlier_level = csr_write_data[ACT_BITS-1:0];
               CSR_HIGH_TIMING_THRESHOLD: high_level = $signed(csr_write_data[THRESH_BITS-1:0]);
               CSR_LOW_TIMING_THRESHOLD:  low_level  = $signed(csr_write_data[THRESH_BITS-1:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            absorb_sample(req_sample_value, req_waveform_last, emits, want);
            if (emits) expected_features.push_back(want);
         end
      end
      pending_count = expected_features.size();
   end

endmodule

### tb/tb_waveform_feature_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform feature extractor testbench
// Feeds directed and randomly shaped detector pulses (noise, outlier spikes,
// afterpulses, short and overlong waveforms) under several threshold
// settings, with random gaps on both channels and one long result hold-off.
// The feature checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_waveform_feature_extractor;

   import wfe_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 60;
   localparam int PHASE_WAVES     = 4;
   localparam int PHASES          = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid         = 1'b0;
   logic                              req_stall;
   logic signed [DEFAULT_SAMPLE_BITS-1:0] req_sample_value = '0;
   logic                              req_waveform_last = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall         = 1'b0;
   logic                              rsp_activated;
   logic signed [PEAK_BITS-1:0]       rsp_peak_value;
   logic [COUNT_BITS-1:0]             rsp_near_peak_count;
   logic [ARRIVAL_BITS-1:0]           rsp_arrival_half_samples;
   logic signed [WIDTH_BITS-1:0]      rsp_width_half_samples;
   logic                              rsp_afterpulse_seen;
   logic signed [AMP_BITS-1:0]        rsp_afterpulse_amplitude;
   logic                              csr_write_enable  = 1'b0;
   logic [CSR_INDEX_BITS-1:0]         csr_index         = CSR_ACTIVATION_THRESHOLD;
   logic [CSR_DATA_BITS-1:0]          csr_write_data    = '0;

   int error_count;
   int pending_count;
   int result_count;

   bit idle_on          = 1'b1;
   bit hold_off_request = 1'b0;
   int sample_count     = 0;
   int waveform_count   = 0;
   int settings_count   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   waveform_feature_extractor dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_sample_value         (req_sample_value),
      .req_waveform_last        (req_waveform_last),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_activated            (rsp_activated),
      .rsp_peak_value           (rsp_peak_value),
      .rsp_near_peak_count      (rsp_near_peak_count),
      .rsp_arrival_half_samples (rsp_arrival_half_samples),
      .rsp_width_half_samples   (rsp_width_half_samples),
      .rsp_afterpulse_seen      (rsp_afterpulse_seen),
      .rsp_afterpulse_amplitude (rsp_afterpulse_amplitude),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data)
   );

   wfe_feature_checker feature_check (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_sample_value         (req_sample_value),
      .req_waveform_last        (req_waveform_last),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_activated            (rsp_activated),
      .rsp_peak_value           (rsp_peak_value),
      .rsp_near_peak_count      (rsp_near_peak_count),
      .rsp_arrival_half_samples (rsp_arrival_half_samples),
      .rsp_width_half_samples   (rsp_width_half_samples),
      .rsp_afterpulse_seen      (rsp_afterpulse_seen),
      .rsp_afterpulse_amplitude (rsp_afterpulse_amplitude),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .error_count              (error_count),
      .pending_count            (pending_count),
      .result_count             (result_count)
   );

   function automatic int triangle(input int i, input int top_at, input int height,
                                   input int rise_len, input int fall_len);
      int d;
      if (i <= top_at) begin
         d = top_at - i;
         return (d >= rise_len) ? 0 : height - height * d / rise_len;
      end
      d = i - top_at;
      return (d >= fall_len) ? 0 : height - height * d / fall_len;
   endfunction

   task automatic send_sample(input int value, input bit last);
      while (idle_on && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_value  <= value[DEFAULT_SAMPLE_BITS-1:0];
      req_waveform_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sample_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      // let the last non-final sample settle
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input int act, input int outl, input int high, input int low);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ACTIVATION_THRESHOLD;
      csr_write_data   <= act[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_index        <= CSR_OUTLIER_DIFFERENCE;
      csr_write_data   <= outl[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_index        <= CSR_HIGH_TIMING_THRESHOLD;
      csr_write_data   <= high[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_index        <= CSR_LOW_TIMING_THRESHOLD;
      csr_write_data   <= low[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_count++;
   endtask

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 31);
         end
      end
   end

   initial begin : stimulus
      int outlier_shape [12];
      int quiet_shape [5];
      int len;
      int pick;
      int top_at;
      int height;
      int rise_len;
      int fall_len;
      int ap_at;
      int ap_height;
      int spike;
      int v;
      int phase_items;
      int phase_waves;

      outlier_shape = '{0, 60, 100, 4095, 120, 95, 70, 40, 60, 150, 80, -4096};
      quiet_shape   = '{5, -3, 30, 12, 0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single-sample and two-sample waveforms at the sample extremes
      send_sample(4095, 1'b1);
      send_sample(-4096, 1'b0);
      send_sample(4095, 1'b1);
      // outlier peak followed by an afterpulse
      foreach (outlier_shape[k]) send_sample(outlier_shape[k], k == 11);
      // never crosses the activation threshold
      foreach (quiet_shape[k]) send_sample(quiet_shape[k], k == 4);
      waveform_count = 4;

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0: apply_settings(ACTIVATION_RESET, OUTLIER_RESET, HIGH_RESET, LOW_RESET);
            1: apply_settings(0, 0, 4095, -4096);
            4: apply_settings(4095, 4095, -4096, 4095);
            default: apply_settings($urandom_range(0, 400), $urandom_range(1, 800),
                                    int'($urandom_range(0, 1500)) - 100,
                                    int'($urandom_range(0, 1500)) - 100);
         endcase
         idle_on = (phase != 2);
         if (phase == 3) hold_off_request = 1'b1;
         phase_items = 0;
         phase_waves = 0;
         while (phase_items < PHASE_ITEMS || phase_waves < PHASE_WAVES) begin
            pick = $urandom_range(0, 19);
            if (pick == 0 || (phase == 5 && phase_waves == 0)) len = $urandom_range(128, 136);
            else if (pick == 1) len = $urandom_range(1, 3);
            else len = $urandom_range(4, 28);
            pick      = $urandom_range(0, 9);
            top_at    = $urandom_range(0, (len > 8) ? len / 2 : len - 1);
            height    = ($urandom_range(0, 9) == 0) ? $urandom_range(3000, 4095)
                                                    : $urandom_range(10, 1500);
            rise_len  = $urandom_range(1, 8);
            fall_len  = $urandom_range(1, 12);
            ap_at     = top_at + $urandom_range(3, 10);
            ap_height = ($urandom_range(0, 2) == 0) ? $urandom_range(5, height / 2 + 10) : 0;
            spike     = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 2000) : 0;
            for (int i = 0; i < len; i++) begin
               if (pick == 0) begin
                  v = int'($urandom_range(0, 8191)) - 4096;
               end else if (pick == 1) begin
                  v = int'($urandom_range(0, 20)) - 10;
               end else begin
                  v = triangle(i, top_at, height, rise_len, fall_len)
                      + triangle(i, ap_at, ap_height, 2, 3)
                      + ((i == top_at) ? spike : 0)
                      + int'($urandom_range(0, 10)) - 5;
               end
               if (v > 4095) v = 4095;
               if (v < -4096) v = -4096;
               send_sample(v, i == len - 1);
            end
            phase_items += len;
            phase_waves++;
            waveform_count++;
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d samples in %0d waveforms under %0d threshold settings",
               sample_count, waveform_count, settings_count);
      $display("Checked %0d feature transactions, one long result hold-off included",
               result_count);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
src/wfe_pkg.sv
src/waveform_feature_extractor.sv
src/wfe_checker.sv
tb/wfe_feature_checker.sv
tb/tb_waveform_feature_extractor.sv
